FILE: src/mm4_pkg.sv
// Shared types and constants for the 4x4 fixed-point matrix multiply core.
// Used by mm4_cell, mm4_collect and matrix_multiply_4x4_core; no dependencies.
package mm4_pkg;

  localparam int DIM       = 4;
  localparam int WORD_W    = 32;
  localparam int FRAC_BITS = 16;
  localparam int PROD_W    = 2 * WORD_W;
  // Four full-width products need two guard bits.
  localparam int ACC_W     = PROD_W + 2;
  localparam int IDX_W     = $clog2(DIM);

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [ACC_W-1:0]  acc_t;
  typedef logic [IDX_W-1:0]         idx_t;

  localparam idx_t ROW_LAST = idx_t'(DIM - 1);
  localparam idx_t COL_LAST = idx_t'(DIM - 1);

  // Element tag that travels along the cell chain with its partial sum.
  typedef struct packed {
    logic valid;
    idx_t row;
    idx_t col;
    logic last;
  } tag_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_RUN,
    ST_DRAIN
  } state_t;

endpackage

FILE: src/mm4_cell.sv
// One multiply-accumulate cell of the chain: holds column k of A and row k of B.
// Depends on mm4_pkg.
module mm4_cell (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          a_wr,
  input  mm4_pkg::idx_t                 a_row,
  input  mm4_pkg::word_t                a_data,
  input  logic                          b_wr,
  input  mm4_pkg::word_t [mm4_pkg::DIM-1:0] b_data,
  input  mm4_pkg::tag_t                 tag_in,
  input  mm4_pkg::acc_t                 psum_in,
  output mm4_pkg::tag_t                 tag_out,
  output mm4_pkg::acc_t                 psum_out
);

  mm4_pkg::word_t a_store [mm4_pkg::DIM];
  mm4_pkg::word_t b_store [mm4_pkg::DIM];

  mm4_pkg::tag_t  tag1;
  mm4_pkg::acc_t  psum1;
  mm4_pkg::prod_t prod;

  always_ff @(posedge clk) begin
    if (a_wr) begin
      a_store[a_row] <= a_data;
    end
    if (b_wr) begin
      for (int j = 0; j < mm4_pkg::DIM; j++) begin
        b_store[j] <= b_data[j];
      end
    end
  end

  // Stage 1 reads the operands for this element and multiplies; stage 2 adds
  // the product to the partial sum handed over by the previous cell.
  always_ff @(posedge clk) begin
    if (en) begin
      prod     <= a_store[tag_in.row] * b_store[tag_in.col];
      psum1    <= psum_in;
      psum_out <= psum1 + {{(mm4_pkg::ACC_W - mm4_pkg::PROD_W){prod[mm4_pkg::PROD_W-1]}}, prod};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag1    <= '0;
      tag_out <= '0;
    end else if (en) begin
      tag1    <= tag_in;
      tag_out <= tag1;
    end
  end

endmodule

FILE: src/mm4_collect.sv
// Scales and saturates finished sums and assembles them into output rows.
// Depends on mm4_pkg.
module mm4_collect (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic                              out_ready,
  input  mm4_pkg::tag_t                     tag_in,
  input  mm4_pkg::acc_t                     psum_in,
  output logic                              out_valid,
  output mm4_pkg::word_t [mm4_pkg::DIM-1:0] out_row,
  output mm4_pkg::idx_t                     out_index,
  output logic                              out_last
);

  localparam int HI_W = mm4_pkg::ACC_W - mm4_pkg::WORD_W + 1;

  mm4_pkg::acc_t  shifted;
  logic [HI_W-1:0] hi;
  logic           fits;
  mm4_pkg::word_t sat;
  mm4_pkg::word_t asm_col [mm4_pkg::DIM];

  always_comb begin
    shifted = psum_in >>> mm4_pkg::FRAC_BITS;
    hi      = shifted[mm4_pkg::ACC_W-1:mm4_pkg::WORD_W-1];
    fits    = (&hi) | ~(|hi);
    if (fits) begin
      sat = shifted[mm4_pkg::WORD_W-1:0];
    end else begin
      sat = {shifted[mm4_pkg::ACC_W-1], {(mm4_pkg::WORD_W-1){~shifted[mm4_pkg::ACC_W-1]}}};
    end
  end

  always_ff @(posedge clk) begin
    if (en && tag_in.valid) begin
      if (tag_in.col != mm4_pkg::COL_LAST) begin
        asm_col[tag_in.col] <= sat;
      end else begin
        for (int j = 0; j < mm4_pkg::DIM - 1; j++) begin
          out_row[j] <= asm_col[j];
        end
        out_row[mm4_pkg::DIM-1] <= sat;
        out_index               <= tag_in.row;
        out_last                <= tag_in.last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en && tag_in.valid && tag_in.col == mm4_pkg::COL_LAST) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

FILE: src/matrix_multiply_4x4_core.sv
// Top level of the 4x4 signed Q16.16 matrix multiply core (C = A x B).
// Depends on mm4_pkg, mm4_cell and mm4_collect.
//
// Each input beat carries row r of A and row r of B, rows in order 0..3. After
// the fourth beat the core stops taking input and sends the 16 elements of C,
// one per cycle unless the output stalls, in row-major order, down a chain of
// four multiply-accumulate cells: cell k holds column k of A and row k of B,
// adds A[i][k]*B[k][j] to the partial sum it receives and hands sum and tag to
// the next cell through its multiply and add stages. The finished sum is shifted
// right by 16 with rounding toward minus infinity and saturated to 32 bits.
// Four output beats follow, one per row of C, with the row number on tuser and
// tlast on row 3. Input is taken again once the chain is empty. A stalled
// output freezes the whole chain.
module matrix_multiply_4x4_core (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // a_col0, a_col1, a_col2, a_col3, b_col0, b_col1, b_col2, b_col3 (32 bits each)
  input  logic [255:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // c_col0, c_col1, c_col2, c_col3 (32 bits each)
  output logic [127:0] m_tdata,
  // row_index
  output logic [1:0]   m_tuser,
  // last_row
  output logic         m_tlast
);

  mm4_pkg::state_t state, state_next;
  mm4_pkg::idx_t   rows_loaded;
  logic [3:0]      issue_cnt;
  logic            issue_valid;
  logic            en;
  logic            in_beat;

  mm4_pkg::tag_t   tag_c  [mm4_pkg::DIM+1];
  mm4_pkg::acc_t   psum_c [mm4_pkg::DIM+1];
  mm4_pkg::word_t [mm4_pkg::DIM-1:0] b_row;
  mm4_pkg::word_t [mm4_pkg::DIM-1:0] c_row;
  logic            chain_busy;

  // The whole chain advances unless a finished row is waiting at the output.
  assign en      = !m_tvalid || m_tready;
  assign in_beat = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mm4_pkg::ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    s_tready    = 1'b0;
    issue_valid = 1'b0;
    unique case (state)
      mm4_pkg::ST_LOAD: begin
        s_tready = 1'b1;
        if (in_beat && rows_loaded == mm4_pkg::ROW_LAST) begin
          state_next = mm4_pkg::ST_RUN;
        end
      end
      mm4_pkg::ST_RUN: begin
        issue_valid = 1'b1;
        if (en && issue_cnt == 4'hF) begin
          state_next = mm4_pkg::ST_DRAIN;
        end
      end
      mm4_pkg::ST_DRAIN: begin
        if (en && tag_c[mm4_pkg::DIM].valid && tag_c[mm4_pkg::DIM].last) begin
          state_next = mm4_pkg::ST_LOAD;
        end
      end
      default: begin
        state_next = mm4_pkg::ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_loaded <= '0;
      issue_cnt   <= '0;
    end else begin
      if (in_beat) begin
        rows_loaded <= rows_loaded + 1'b1;
      end
      if (issue_valid && en) begin
        issue_cnt <= issue_cnt + 1'b1;
      end
    end
  end

  always_comb begin
    tag_c[0].valid = issue_valid;
    tag_c[0].row   = issue_cnt[3:2];
    tag_c[0].col   = issue_cnt[1:0];
    tag_c[0].last  = (issue_cnt == 4'hF);
    psum_c[0]      = '0;
    for (int j = 0; j < mm4_pkg::DIM; j++) begin
      b_row[j] = s_tdata[(mm4_pkg::DIM + j) * mm4_pkg::WORD_W +: mm4_pkg::WORD_W];
    end
  end

  for (genvar k = 0; k < mm4_pkg::DIM; k++) begin : g_cell
    mm4_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .a_wr     (in_beat),
      .a_row    (rows_loaded),
      .a_data   (s_tdata[k * mm4_pkg::WORD_W +: mm4_pkg::WORD_W]),
      .b_wr     (in_beat && rows_loaded == mm4_pkg::idx_t'(k)),
      .b_data   (b_row),
      .tag_in   (tag_c[k]),
      .psum_in  (psum_c[k]),
      .tag_out  (tag_c[k+1]),
      .psum_out (psum_c[k+1])
    );
  end

  mm4_collect u_collect (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .out_ready (m_tready),
    .tag_in    (tag_c[mm4_pkg::DIM]),
    .psum_in   (psum_c[mm4_pkg::DIM]),
    .out_valid (m_tvalid),
    .out_row   (c_row),
    .out_index (m_tuser),
    .out_last  (m_tlast)
  );

  assign m_tdata = c_row;

  always_comb begin
    chain_busy = 1'b0;
    for (int k = 1; k <= mm4_pkg::DIM; k++) begin
      chain_busy = chain_busy | tag_c[k].valid;
    end
  end

  // The operand stores are never written while an element is still reading them.
  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    in_beat |-> !chain_busy)
    else $error("input beat accepted while the cell chain is busy");

  a_count_idle: assert property (@(posedge clk) disable iff (rst)
    state != mm4_pkg::ST_LOAD |-> rows_loaded == '0)
    else $error("row count not cleared during the product");

  a_issue_hold: assert property (@(posedge clk) disable iff (rst)
    (!en && state == mm4_pkg::ST_RUN) |=> $stable(issue_cnt))
    else $error("element issued while the chain is frozen");

  a_last_row: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tlast == (m_tuser == mm4_pkg::ROW_LAST)))
    else $error("last-row mark does not match the row number");

endmodule
